>>> rtl/core/pbg_pkg.sv
// Package for the pulse burst generator: field widths, beat layouts,
// result codes and the result packing function.
// Used by the top level and by its port checker; depends on nothing.
package pbg_pkg;

  localparam int COUNT_W     = 32;
  localparam int FREQ_W      = 32;
  localparam int DUTY_W      = 14;
  localparam int PULSES_W    = 31;
  localparam int ERR_W       = 4;
  localparam int IN_TDATA_W  = 80;
  localparam int OUT_TDATA_W = 8;

  localparam int IN_COUNT_LSB = 0;
  localparam int IN_FREQ_LSB  = IN_COUNT_LSB + COUNT_W;
  localparam int IN_DUTY_LSB  = IN_FREQ_LSB + FREQ_W;

  localparam int OUT_LEVEL_BIT = 0;
  localparam int OUT_ERR_LSB   = 1;
  localparam int OUT_ACC_BIT   = OUT_ERR_LSB + ERR_W;
  localparam int OUT_DONE_BIT  = OUT_ACC_BIT + 1;
  localparam int OUT_BUSY_BIT  = OUT_DONE_BIT + 1;

  localparam logic [DUTY_W-1:0] DUTY_FULL  = 14'd10000;
  localparam int                DUTY_DIV   = 10000;
  localparam int                ROUND_HALF = 5000;

  typedef enum logic [ERR_W-1:0] {
    ERR_OK         = 4'd0,
    ERR_COUNT_ZERO = 4'd1,
    ERR_FREQ_ZERO  = 4'd2,
    ERR_DUTY_RANGE = 4'd3,
    ERR_COUNT_BIG  = 4'd4,
    ERR_FREQ_HIGH  = 4'd5,
    ERR_SEG_LONG   = 4'd6,
    ERR_HALF_LONG  = 4'd7,
    ERR_BUSY       = 4'd8
  } pbg_err_e;

  function automatic logic [OUT_TDATA_W-1:0] pack_result(
    input logic     level,
    input pbg_err_e err,
    input logic     acc,
    input logic     done,
    input logic     busy
  );
    logic [OUT_TDATA_W-1:0] r;
    r = '0;
    r[OUT_LEVEL_BIT]              = level;
    r[OUT_ERR_LSB +: ERR_W]       = err;
    r[OUT_ACC_BIT]                = acc;
    r[OUT_DONE_BIT]               = done;
    r[OUT_BUSY_BIT]               = busy;
    return r;
  endfunction

endpackage

>>> rtl/core/pwm_pulse_burst_generator.sv
// Pulse burst generator: request validation, bit-serial period and duty
// arithmetic, and the per-microsecond segment sequencer.
// Depends on pbg_pkg.
//
//   Channel   Direction  tdata (lowest bit first)                     tuser
//   s_axis    in         pulse_count, frequency_hz, duty_hundredths   kind
//   m_axis    out        line_level, error_code, accepted,            none
//                        burst_done, busy_res
//
// A tick, a busy request or a request failing the field checks is answered from the idle state.
// An accepted request runs a restoring divider one quotient bit per cycle, then a
// check state; a normal duty adds a shift-add multiply over the duty bits, a load
// state, a second division and a finishing state.
// Reset is asynchronous and leaves the line idle and low.
// A new beat is taken once the state machine is idle and the result register is
// empty or being emptied in the same cycle.
module pwm_pulse_burst_generator #(
  parameter int MAX_SEGMENT_TICKS = 32767,
  parameter int TICKS_PER_SECOND  = 1000000
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  // pulse_count, frequency_hz, duty_hundredths, two unused bits
  input  logic [pbg_pkg::IN_TDATA_W-1:0]     s_axis_tdata_i,
  // kind
  input  logic                               s_axis_tuser_i,
  output logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i,
  // line_level, error_code, accepted, burst_done, busy_res
  output logic [pbg_pkg::OUT_TDATA_W-1:0]    m_axis_tdata_o
);
  import pbg_pkg::*;

  localparam int SEG_W    = $clog2(MAX_SEGMENT_TICKS + 1);
  localparam int TW       = $clog2(TICKS_PER_SECOND + 1);
  localparam int PW       = TW + DUTY_W;
  localparam int CNT_W    = $clog2((TW > DUTY_W) ? TW : DUTY_W);
  localparam int MAX_CLIP = (MAX_SEGMENT_TICKS < 2**TW) ? MAX_SEGMENT_TICKS : 2**TW - 1;
  localparam logic [TW-1:0] SEG_LIM = TW'(MAX_CLIP);
  localparam logic [TW-1:0] TPS     = TW'(TICKS_PER_SECOND);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV_PERIOD,
    ST_CHECK,
    ST_MUL,
    ST_LOAD,
    ST_DIV_HIGH,
    ST_FINISH
  } state_e;

  state_e                 state_q;
  logic                   running_q;
  logic                   second_half_q;
  logic                   first_level_q;
  logic                   second_level_q;
  logic [SEG_W-1:0]       first_dur_q;
  logic [SEG_W-1:0]       second_dur_q;
  logic [SEG_W-1:0]       seg_ticks_q;
  logic [PULSES_W-1:0]    pulses_left_q;
  logic [PULSES_W-1:0]    req_count_q;
  logic [DUTY_W-1:0]      duty_q;
  logic [TW-1:0]          period_q;
  logic [FREQ_W-1:0]      div_sor_q;
  logic [FREQ_W-1:0]      div_rem_q;
  logic [TW-1:0]          div_quo_q;
  logic [PW-1:0]          acc_q;
  logic [CNT_W-1:0]       cnt_q;
  logic                   out_valid_q;
  logic [OUT_TDATA_W-1:0] out_data_q;

  logic [COUNT_W-1:0]     in_count;
  logic [FREQ_W-1:0]      in_freq;
  logic [DUTY_W-1:0]      in_duty;
  logic                   in_fire;
  pbg_err_e               pre_err;
  logic                   cur_level;

  logic [FREQ_W:0]        trial;
  logic [FREQ_W:0]        trial_sub;
  logic                   trial_ge;
  logic [FREQ_W-1:0]      div_rem_nxt;
  logic [TW-1:0]          div_quo_nxt;
  logic [PW-1:0]          round_sum;

  logic [TW-1:0]          half_lo;
  logic [TW-1:0]          half_hi;
  logic                   half_bad;
  logic [TW-1:0]          high_c;
  logic [TW-1:0]          low_c;
  logic                   seg_bad;

  logic [SEG_W-1:0]       seg_len;
  logic [SEG_W-1:0]       seg_next;
  logic                   seg_end;
  logic                   last_pulse;

  assign in_count = s_axis_tdata_i[IN_COUNT_LSB +: COUNT_W];
  assign in_freq  = s_axis_tdata_i[IN_FREQ_LSB +: FREQ_W];
  assign in_duty  = s_axis_tdata_i[IN_DUTY_LSB +: DUTY_W];

  assign s_axis_tready_o = (state_q == ST_IDLE) && (!out_valid_q || m_axis_tready_i);
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

  assign cur_level = running_q && (second_half_q ? second_level_q : first_level_q);

  always_comb begin
    if (running_q) begin
      pre_err = ERR_BUSY;
    end else if (in_count == '0) begin
      pre_err = ERR_COUNT_ZERO;
    end else if (in_freq == '0) begin
      pre_err = ERR_FREQ_ZERO;
    end else if (in_duty > DUTY_FULL) begin
      pre_err = ERR_DUTY_RANGE;
    end else if (in_count[COUNT_W-1]) begin
      pre_err = ERR_COUNT_BIG;
    end else begin
      pre_err = ERR_OK;
    end
  end

  // One restoring division step: the next dividend bit enters from the quotient register.
  assign trial       = {div_rem_q, div_quo_q[TW-1]};
  assign trial_sub   = trial - {1'b0, div_sor_q};
  assign trial_ge    = trial >= {1'b0, div_sor_q};
  assign div_rem_nxt = trial_ge ? trial_sub[FREQ_W-1:0] : trial[FREQ_W-1:0];
  assign div_quo_nxt = {div_quo_q[TW-2:0], trial_ge};
  assign round_sum   = acc_q + PW'(ROUND_HALF);

  assign half_lo  = div_quo_q >> 1;
  assign half_hi  = div_quo_q - half_lo;
  assign half_bad = (half_lo > SEG_LIM) || (half_hi > SEG_LIM);

  always_comb begin
    if (div_quo_q == '0) begin
      high_c = TW'(1);
    end else if (div_quo_q >= period_q) begin
      high_c = period_q - TW'(1);
    end else begin
      high_c = div_quo_q;
    end
  end
  assign low_c   = period_q - high_c;
  assign seg_bad = (high_c > SEG_LIM) || (low_c > SEG_LIM);

  assign seg_len    = second_half_q ? second_dur_q : first_dur_q;
  assign seg_next   = seg_ticks_q + SEG_W'(1);
  assign seg_end    = seg_next >= seg_len;
  assign last_pulse = pulses_left_q <= PULSES_W'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      running_q      <= 1'b0;
      second_half_q  <= 1'b0;
      first_level_q  <= 1'b0;
      second_level_q <= 1'b0;
      first_dur_q    <= '0;
      second_dur_q   <= '0;
      seg_ticks_q    <= '0;
      pulses_left_q  <= '0;
      req_count_q    <= '0;
      duty_q         <= '0;
      period_q       <= '0;
      div_sor_q      <= '0;
      div_rem_q      <= '0;
      div_quo_q      <= '0;
      acc_q          <= '0;
      cnt_q          <= '0;
      out_valid_q    <= 1'b0;
      out_data_q     <= '0;
    end else begin
      if (out_valid_q && m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_fire) begin
            if (s_axis_tuser_i) begin
              out_valid_q <= 1'b1;
              if (running_q) begin
                if (seg_end) begin
                  seg_ticks_q   <= '0;
                  second_half_q <= !second_half_q;
                  if (second_half_q) begin
                    pulses_left_q <= pulses_left_q - PULSES_W'(1);
                    if (last_pulse) begin
                      running_q <= 1'b0;
                    end
                  end
                end else begin
                  seg_ticks_q <= seg_next;
                end
                out_data_q <= pack_result(cur_level, ERR_OK, 1'b0,
                                          seg_end && second_half_q && last_pulse,
                                          !(seg_end && second_half_q && last_pulse));
              end else begin
                out_data_q <= pack_result(1'b0, ERR_OK, 1'b0, 1'b0, 1'b0);
              end
            end else if (pre_err != ERR_OK) begin
              out_valid_q <= 1'b1;
              out_data_q  <= pack_result(cur_level, pre_err, 1'b0, 1'b0, running_q);
            end else begin
              div_rem_q   <= '0;
              div_quo_q   <= TPS;
              div_sor_q   <= in_freq;
              cnt_q       <= CNT_W'(TW - 1);
              req_count_q <= in_count[PULSES_W-1:0];
              duty_q      <= in_duty;
              state_q     <= ST_DIV_PERIOD;
            end
          end
        end
        ST_DIV_PERIOD: begin
          div_rem_q <= div_rem_nxt;
          div_quo_q <= div_quo_nxt;
          cnt_q     <= cnt_q - CNT_W'(1);
          if (cnt_q == '0) begin
            state_q <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          period_q <= div_quo_q;
          if (div_quo_q < TW'(2)) begin
            out_valid_q <= 1'b1;
            out_data_q  <= pack_result(1'b0, ERR_FREQ_HIGH, 1'b0, 1'b0, 1'b0);
            state_q     <= ST_IDLE;
          end else if ((duty_q == '0) || (duty_q == DUTY_FULL)) begin
            out_valid_q <= 1'b1;
            state_q     <= ST_IDLE;
            if (half_bad) begin
              out_data_q <= pack_result(1'b0, ERR_HALF_LONG, 1'b0, 1'b0, 1'b0);
            end else begin
              first_dur_q    <= SEG_W'(half_lo);
              second_dur_q   <= SEG_W'(half_hi);
              first_level_q  <= (duty_q != '0);
              second_level_q <= (duty_q != '0);
              pulses_left_q  <= req_count_q;
              second_half_q  <= 1'b0;
              seg_ticks_q    <= '0;
              running_q      <= 1'b1;
              out_data_q     <= pack_result(duty_q != '0, ERR_OK, 1'b1, 1'b0, 1'b1);
            end
          end else begin
            acc_q   <= '0;
            cnt_q   <= CNT_W'(DUTY_W - 1);
            state_q <= ST_MUL;
          end
        end
        ST_MUL: begin
          acc_q  <= {acc_q[PW-2:0], 1'b0} + (duty_q[DUTY_W-1] ? PW'(period_q) : '0);
          duty_q <= {duty_q[DUTY_W-2:0], 1'b0};
          cnt_q  <= cnt_q - CNT_W'(1);
          if (cnt_q == '0) begin
            state_q <= ST_LOAD;
          end
        end
        ST_LOAD: begin
          div_rem_q <= FREQ_W'(round_sum[PW-1:TW]);
          div_quo_q <= round_sum[TW-1:0];
          div_sor_q <= FREQ_W'(DUTY_DIV);
          cnt_q     <= CNT_W'(TW - 1);
          state_q   <= ST_DIV_HIGH;
        end
        ST_DIV_HIGH: begin
          div_rem_q <= div_rem_nxt;
          div_quo_q <= div_quo_nxt;
          cnt_q     <= cnt_q - CNT_W'(1);
          if (cnt_q == '0) begin
            state_q <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          out_valid_q <= 1'b1;
          state_q     <= ST_IDLE;
          if (seg_bad) begin
            out_data_q <= pack_result(1'b0, ERR_SEG_LONG, 1'b0, 1'b0, 1'b0);
          end else begin
            first_dur_q    <= SEG_W'(high_c);
            second_dur_q   <= SEG_W'(low_c);
            first_level_q  <= 1'b1;
            second_level_q <= 1'b0;
            pulses_left_q  <= req_count_q;
            second_half_q  <= 1'b0;
            seg_ticks_q    <= '0;
            running_q      <= 1'b1;
            out_data_q     <= pack_result(1'b1, ERR_OK, 1'b1, 1'b0, 1'b1);
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

>>> rtl/core/pbg_checker.sv
// Port checker for the pulse burst generator, attached by a bind statement.
// Depends on pbg_pkg and on the top level's port list.
module pbg_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            s_axis_tvalid_i,
  input logic                            s_axis_tready_o,
  input logic [pbg_pkg::IN_TDATA_W-1:0]  s_axis_tdata_i,
  input logic                            s_axis_tuser_i,
  input logic                            m_axis_tvalid_o,
  input logic                            m_axis_tready_i,
  input logic [pbg_pkg::OUT_TDATA_W-1:0] m_axis_tdata_o
);
  import pbg_pkg::*;

  logic [ERR_W-1:0] out_err;
  assign out_err = m_axis_tdata_o[OUT_ERR_LSB +: ERR_W];

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("result beat changed while stalled");

  a_accept_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tdata_o[OUT_ACC_BIT] |->
      out_err == ERR_OK && m_axis_tdata_o[OUT_BUSY_BIT])
    else $error("accepted request without ok code and busy flag");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tdata_o[OUT_DONE_BIT] |->
      !m_axis_tdata_o[OUT_BUSY_BIT] && !m_axis_tdata_o[OUT_ACC_BIT] && out_err == ERR_OK)
    else $error("burst end beat inconsistent");

  a_err_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> out_err <= ERR_BUSY)
    else $error("result code out of range");

  a_idle_low: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tdata_o[OUT_BUSY_BIT] && !m_axis_tdata_o[OUT_DONE_BIT] |->
      !m_axis_tdata_o[OUT_LEVEL_BIT])
    else $error("line not low while idle");

endmodule

bind pwm_pulse_burst_generator pbg_checker u_pbg_checker (.*);

>>> sim/tb_pwm_pulse_burst_generator.sv
// Self-checking testbench for the pulse burst generator: a directed table of request and
// tick beats, then random bursts, checked against a cycle-free model of the burst sequencer.
// Depends on pbg_pkg and pwm_pulse_burst_generator.
module tb_pwm_pulse_burst_generator;
  import pbg_pkg::*;

  localparam logic        KIND_REQUEST  = 1'b0;
  localparam logic        KIND_TICK     = 1'b1;
  localparam longint      TICKS_PER_S   = 1000000;
  localparam longint      SEG_LIMIT     = 32767;
  localparam longint      DUTY_SCALE    = 10000;
  localparam longint      DUTY_ROUND    = 5000;
  localparam logic [31:0] COUNT_MAX     = 32'h7FFF_FFFF;
  localparam int          RANDOM_ITEMS  = 550;
  localparam int          DRAIN_CYCLES  = 80;
  localparam int          TAIL_TICKS    = 4000;
  localparam int unsigned CYCLE_LIMIT   = 400000;
  localparam int          IDLE_PERCENT  = 32;

  typedef struct packed {
    logic     level;
    pbg_err_e err;
    logic     acc;
    logic     done;
    logic     busy;
  } burst_result_t;

  typedef struct {
    logic          kind;
    logic [31:0]   cnt;
    logic [31:0]   freq;
    logic [13:0]   duty;
    bit            typed;
    burst_result_t res;
  } directed_row_t;

  localparam burst_result_t NO_RESULT = '{1'b0, ERR_OK, 1'b0, 1'b0, 1'b0};

  logic                   clk      = 1'b0;
  logic                   rst_n    = 1'b0;
  logic                   s_valid  = 1'b0;
  logic [IN_TDATA_W-1:0]  s_data   = '0;
  logic                   s_user   = 1'b0;
  logic                   m_ready  = 1'b0;
  logic                   s_axis_tready_o;
  logic                   m_axis_tvalid_o;
  logic [OUT_TDATA_W-1:0] m_axis_tdata_o;

  bit                     steady   = 1'b0;
  int                     fail_count = 0;
  burst_result_t          results_pending[$];

  logic [15:0] seg_first_len  = '0;
  logic [15:0] seg_second_len = '0;
  logic        lvl_first      = 1'b0;
  logic        lvl_second     = 1'b0;
  logic [30:0] pulses_remaining = '0;
  logic        second_half    = 1'b0;
  logic [15:0] seg_elapsed    = '0;
  logic        burst_running  = 1'b0;

  directed_row_t directed_rows [28] = '{
    '{KIND_TICK,    32'd0,        32'd0,        14'd0,     1'b1, NO_RESULT},
    '{KIND_REQUEST, 32'd0,        32'd1000,     14'd5000,  1'b1,
      '{1'b0, ERR_COUNT_ZERO, 1'b0, 1'b0, 1'b0}},
    '{KIND_REQUEST, 32'hFFFF_FFFF, 32'd0,       14'd16383, 1'b1,
      '{1'b0, ERR_FREQ_ZERO, 1'b0, 1'b0, 1'b0}},
    '{KIND_REQUEST, 32'd5,        32'd1000,     14'd16383, 1'b1,
      '{1'b0, ERR_DUTY_RANGE, 1'b0, 1'b0, 1'b0}},
    '{KIND_REQUEST, 32'h8000_0000, 32'd1000,    14'd5000,  1'b1,
      '{1'b0, ERR_COUNT_BIG, 1'b0, 1'b0, 1'b0}},
    '{KIND_REQUEST, 32'd1,        32'd500001,   14'd5000,  1'b1,
      '{1'b0, ERR_FREQ_HIGH, 1'b0, 1'b0, 1'b0}},
    '{KIND_REQUEST, 32'd1,        32'hFFFF_FFFF, 14'd0,    1'b1,
      '{1'b0, ERR_FREQ_HIGH, 1'b0, 1'b0, 1'b0}},
    '{KIND_REQUEST, 32'd1,        32'd20,       14'd100,   1'b1,
      '{1'b0, ERR_SEG_LONG, 1'b0, 1'b0, 1'b0}},
    '{KIND_REQUEST, 32'd1,        32'd15,       14'd0,     1'b1,
      '{1'b0, ERR_HALF_LONG, 1'b0, 1'b0, 1'b0}},
    '{KIND_REQUEST, 32'd1,        32'd15,       14'd10000, 1'b1,
      '{1'b0, ERR_HALF_LONG, 1'b0, 1'b0, 1'b0}},
    '{KIND_REQUEST, 32'd2,        32'd500000,   14'd1,     1'b0, NO_RESULT},
    '{KIND_REQUEST, COUNT_MAX,    32'd1,        14'd0,     1'b0, NO_RESULT},
    '{KIND_TICK,    32'd0,        32'd0,        14'd0,     1'b0, NO_RESULT},
    '{KIND_TICK,    32'd0,        32'd0,        14'd0,     1'b0, NO_RESULT},
    '{KIND_TICK,    32'd0,        32'd0,        14'd0,     1'b0, NO_RESULT},
    '{KIND_TICK,    32'd0,        32'd0,        14'd0,     1'b0, NO_RESULT},
    '{KIND_REQUEST, 32'd1,        32'd500000,   14'd9999,  1'b0, NO_RESULT},
    '{KIND_TICK,    32'd0,        32'd0,        14'd0,     1'b0, NO_RESULT},
    '{KIND_TICK,    32'd0,        32'd0,        14'd0,     1'b0, NO_RESULT},
    '{KIND_REQUEST, 32'd1,        32'd333333,   14'd0,     1'b0, NO_RESULT},
    '{KIND_TICK,    32'd0,        32'd0,        14'd0,     1'b0, NO_RESULT},
    '{KIND_TICK,    32'd0,        32'd0,        14'd0,     1'b0, NO_RESULT},
    '{KIND_TICK,    32'd0,        32'd0,        14'd0,     1'b0, NO_RESULT},
    '{KIND_REQUEST, 32'd1,        32'd250000,   14'd10000, 1'b0, NO_RESULT},
    '{KIND_TICK,    32'd0,        32'd0,        14'd0,     1'b0, NO_RESULT},
    '{KIND_TICK,    32'd0,        32'd0,        14'd0,     1'b0, NO_RESULT},
    '{KIND_TICK,    32'd0,        32'd0,        14'd0,     1'b0, NO_RESULT},
    '{KIND_TICK,    32'd0,        32'd0,        14'd0,     1'b0, NO_RESULT}
  };

  pwm_pulse_burst_generator dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_data),
    .s_axis_tuser_i  (s_user),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Advances the burst state by one accepted beat and returns the beat it should produce.
  function automatic burst_result_t burst_model_step(input logic kind, input logic [31:0] cnt,
                                                     input logic [31:0] freq,
                                                     input logic [13:0] duty);
    burst_result_t r;
    longint        period;
    longint        hi_len;
    longint        lo_len;
    logic          lvl_a;
    logic          lvl_b;
    r      = NO_RESULT;
    period = 0;
    hi_len = 0;
    lo_len = 0;
    lvl_a  = 1'b0;
    lvl_b  = 1'b0;
    if (kind == KIND_REQUEST) begin
      if (freq != 0) period = TICKS_PER_S / longint'(freq);
      if (burst_running) r.err = ERR_BUSY;
      else if (cnt == 0) r.err = ERR_COUNT_ZERO;
      else if (freq == 0) r.err = ERR_FREQ_ZERO;
      else if (duty > DUTY_FULL) r.err = ERR_DUTY_RANGE;
      else if (cnt > COUNT_MAX) r.err = ERR_COUNT_BIG;
      else if (period < 2) r.err = ERR_FREQ_HIGH;
      else if (duty != 0 && duty != DUTY_FULL) begin
        hi_len = (period * longint'(duty) + DUTY_ROUND) / DUTY_SCALE;
        if (hi_len == 0) hi_len = 1;
        if (hi_len >= period) hi_len = period - 1;
        lo_len = period - hi_len;
        lvl_a  = 1'b1;
        if (hi_len > SEG_LIMIT || lo_len > SEG_LIMIT) r.err = ERR_SEG_LONG;
      end else begin
        hi_len = period / 2;
        lo_len = period - hi_len;
        lvl_a  = (duty != 0);
        lvl_b  = lvl_a;
        if (hi_len == 0 || hi_len > SEG_LIMIT || lo_len > SEG_LIMIT) r.err = ERR_HALF_LONG;
      end
      if (r.err == ERR_OK) begin
        seg_first_len    = hi_len[15:0];
        seg_second_len   = lo_len[15:0];
        lvl_first        = lvl_a;
        lvl_second       = lvl_b;
        pulses_remaining = cnt[30:0];
        second_half      = 1'b0;
        seg_elapsed      = '0;
        burst_running    = 1'b1;
        r.acc            = 1'b1;
      end
      if (burst_running) r.level = second_half ? lvl_second : lvl_first;
    end else if (burst_running) begin
      r.level     = second_half ? lvl_second : lvl_first;
      seg_elapsed = seg_elapsed + 1'b1;
      if (seg_elapsed >= (second_half ? seg_second_len : seg_first_len)) begin
        seg_elapsed = '0;
        if (!second_half) begin
          second_half = 1'b1;
        end else begin
          second_half = 1'b0;
          if (pulses_remaining != 0) pulses_remaining = pulses_remaining - 1'b1;
          if (pulses_remaining == 0) begin
            burst_running = 1'b0;
            r.done        = 1'b1;
          end
        end
      end
    end
    r.busy = burst_running;
    return r;
  endfunction

  task automatic send_beat(input logic kind, input logic [31:0] cnt, input logic [31:0] freq,
                           input logic [13:0] duty, input bit typed,
                           input burst_result_t typed_res);
    burst_result_t pred;
    while (!steady && $urandom_range(0, 99) < IDLE_PERCENT) begin
      s_valid <= 1'b0;
      @(posedge clk);
    end
    s_valid <= 1'b1;
    s_user  <= kind;
    s_data  <= {2'b00, duty, freq, cnt};
    @(posedge clk);
    while (!s_axis_tready_o) @(posedge clk);
    pred = burst_model_step(kind, cnt, freq, duty);
    results_pending.push_back(typed ? typed_res : pred);
  endtask

  // Mostly short periods and few pulses, so that many bursts run to completion.
  task automatic pick_burst_request(output logic [31:0] cnt, output logic [31:0] freq,
                                    output logic [13:0] duty);
    int r;
    r    = $urandom_range(0, 99);
    cnt  = (r < 80) ? $urandom_range(1, 3) : $urandom_range(4, 8);
    freq = $urandom_range(25000, 500000);
    if (r >= 95) begin
      cnt  = 1;
      freq = $urandom_range(5000, 25000);
    end
    r = $urandom_range(0, 99);
    if (r < 12) duty = 14'd0;
    else if (r < 24) duty = DUTY_FULL;
    else if (r < 34) duty = 14'($urandom_range(1, 60));
    else if (r < 44) duty = 14'($urandom_range(9940, 9999));
    else duty = 14'($urandom_range(0, 10000));
  endtask

  initial begin : result_monitor
    burst_result_t want;
    burst_result_t got;
    forever begin
      @(posedge clk);
      if (m_axis_tvalid_o && m_ready) begin
        got.level = m_axis_tdata_o[OUT_LEVEL_BIT];
        got.err   = pbg_err_e'(m_axis_tdata_o[OUT_ERR_LSB +: ERR_W]);
        got.acc   = m_axis_tdata_o[OUT_ACC_BIT];
        got.done  = m_axis_tdata_o[OUT_DONE_BIT];
        got.busy  = m_axis_tdata_o[OUT_BUSY_BIT];
        if (results_pending.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("Result beat %h arrived with nothing pending", m_axis_tdata_o);
        end else begin
          want = results_pending.pop_front();
          if (got.level !== want.level || got.err !== want.err || got.acc !== want.acc ||
              got.done !== want.done || got.busy !== want.busy) begin
            fail_count++;
            if (fail_count <= 10) begin
              $display("Mismatch: expected level %b err %0d acc %b done %b busy %b",
                       want.level, want.err, want.acc, want.done, want.busy);
              $display("          got      level %b err %0d acc %b done %b busy %b",
                       got.level, got.err, got.acc, got.done, got.busy);
            end
          end
        end
      end
      m_ready <= steady || ($urandom_range(0, 99) >= IDLE_PERCENT);
    end
  end

  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("pwm_pulse_burst_generator test failed");
    $finish;
  end

  initial begin : stimulus
    logic [31:0] cnt;
    logic [31:0] freq;
    logic [13:0] duty;
    int          roll;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i])
      send_beat(directed_rows[i].kind, directed_rows[i].cnt, directed_rows[i].freq,
                directed_rows[i].duty, directed_rows[i].typed, directed_rows[i].res);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      steady = (n >= 200 && n < 320);
      roll   = $urandom_range(0, 99);
      if (burst_running && roll < 90) begin
        send_beat(KIND_TICK, $urandom, $urandom, 14'($urandom), 1'b0, NO_RESULT);
      end else if (roll < 65 || (burst_running && roll < 95)) begin
        pick_burst_request(cnt, freq, duty);
        send_beat(KIND_REQUEST, cnt, freq, duty, 1'b0, NO_RESULT);
      end else if (roll < 80) begin
        // A well-formed request with one field pushed out of range.
        pick_burst_request(cnt, freq, duty);
        case ($urandom_range(0, 5))
          0: cnt = 32'd0;
          1: freq = 32'd0;
          2: duty = 14'($urandom_range(10001, 16383));
          3: cnt = $urandom_range(32'h8000_0000, 32'hFFFF_FFFF);
          4: freq = $urandom_range(500001, 32'hFFFF_FFFF);
          default: freq = $urandom_range(1, 15);
        endcase
        send_beat(KIND_REQUEST, cnt, freq, duty, 1'b0, NO_RESULT);
      end else if (roll < 90) begin
        send_beat(KIND_REQUEST, $urandom, $urandom, 14'($urandom_range(0, 16383)),
                  1'b0, NO_RESULT);
      end else begin
        send_beat(KIND_TICK, $urandom, $urandom, 14'($urandom), 1'b0, NO_RESULT);
      end
    end
    steady = 1'b0;

    // Let any open burst run out within a bound, then start the longest burst allowed and
    // probe it.
    for (int t = 0; t < TAIL_TICKS && burst_running; t++)
      send_beat(KIND_TICK, 32'd0, 32'd0, 14'd0, 1'b0, NO_RESULT);
    send_beat(KIND_REQUEST, COUNT_MAX, 32'd500000, 14'd5000, 1'b0, NO_RESULT);
    repeat (6) send_beat(KIND_TICK, 32'd0, 32'd0, 14'd0, 1'b0, NO_RESULT);
    send_beat(KIND_REQUEST, 32'd1, 32'd1000, 14'd5000, 1'b0, NO_RESULT);
    s_valid <= 1'b0;

    while (results_pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("pwm_pulse_burst_generator test passed");
    end else begin
      $display("pwm_pulse_burst_generator test failed");
    end
    $finish;
  end

endmodule

>>> pwm_pulse_burst_generator.f
rtl/core/pbg_pkg.sv
rtl/core/pwm_pulse_burst_generator.sv
rtl/core/pbg_checker.sv
sim/tb_pwm_pulse_burst_generator.sv
